FILE: hw/rtl/gf2d_pkg.sv
// Shared constants, status codes and the pipeline flag type for the 2D gravity force unit.
// Used by the channel interfaces, the root and divider cells and the top level.
package gf2d_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MASS_BITS_DEF  = 16;
  localparam int GAIN_BITS      = 12;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 12'd1708;
  localparam int FORCE_BITS     = 52;
  localparam int FRAC_SHIFT     = 56;
  localparam int SQRT_SHIFT     = 32;
  localparam logic [FORCE_BITS-1:0] FORCE_MAX = '1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ZERO_MASS  = 2'd1,
    STATUS_COINCIDENT = 2'd2,
    STATUS_SATURATED  = 2'd3
  } status_t;

  typedef struct packed {
    logic zero_mass;
    logic coincident;
    logic sat_x;
    logic sat_y;
  } flags_t;

endpackage

FILE: hw/rtl/gf2d_channels.sv
// Valid/ready channel interfaces for body-pair items and force items.
// Depends on gf2d_pkg for the default widths and the force width.
interface gf2d_in_if #(
  parameter int COORD_BITS = gf2d_pkg::COORD_BITS_DEF,
  parameter int MASS_BITS  = gf2d_pkg::MASS_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic        [MASS_BITS-1:0]  first_mass;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic        [MASS_BITS-1:0]  second_mass;

  modport source (output valid, first_x, first_y, first_mass, second_x, second_y,
                  second_mass, input ready);
  modport sink (input valid, first_x, first_y, first_mass, second_x, second_y,
                second_mass, output ready);
endinterface

interface gf2d_out_if;
  logic                              valid;
  logic                              ready;
  logic [gf2d_pkg::FORCE_BITS-1:0]   force_x;
  logic [gf2d_pkg::FORCE_BITS-1:0]   force_y;
  logic [1:0]                        status;

  modport source (output valid, force_x, force_y, status, input ready);
  modport sink (input valid, force_x, force_y, status, output ready);
endinterface

FILE: hw/rtl/gf2d_sqrt_cell.sv
// One cell of the integer square root chain: settles one root bit per cell.
// Depends on gf2d_pkg for the flag struct.
module gf2d_sqrt_cell #(
  parameter int DBITS  = 33,
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DBITS+1:0]       in_rem,
  input  logic [DBITS-1:0]       in_root,
  input  logic [2*DBITS-1:0]     in_rad,
  input  logic [SIDE_W-1:0]      in_side,
  input  gf2d_pkg::flags_t       in_flags,
  output logic                   out_valid,
  output logic [DBITS+1:0]       out_rem,
  output logic [DBITS-1:0]       out_root,
  output logic [2*DBITS-1:0]     out_rad,
  output logic [SIDE_W-1:0]      out_side,
  output gf2d_pkg::flags_t       out_flags
);
  import gf2d_pkg::*;

  logic [DBITS+1:0] rem_sh;
  logic [DBITS+1:0] trial;
  logic             take;

  always_comb begin
    rem_sh = {in_rem[DBITS-1:0], in_rad[2*DBITS-1 -: 2]};
    trial  = {in_root, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem   <= take ? (rem_sh - trial) : rem_sh;
      out_root  <= {in_root[DBITS-2:0], take};
      out_rad   <= {in_rad[2*DBITS-3:0], 2'b00};
      out_side  <= in_side;
      out_flags <= in_flags;
    end
  end
endmodule

FILE: hw/rtl/gf2d_div_cell.sv
// One cell of the dual restoring divider chain: one quotient bit for x and y per cell.
// Depends on gf2d_pkg for the flag struct and the force width.
module gf2d_div_cell #(
  parameter int CW = 99
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [CW-1:0]                   in_den,
  input  logic [CW-1:0]                   in_rem_x,
  input  logic [CW-1:0]                   in_rem_y,
  input  logic [gf2d_pkg::FORCE_BITS-1:0] in_q_x,
  input  logic [gf2d_pkg::FORCE_BITS-1:0] in_q_y,
  input  gf2d_pkg::flags_t                in_flags,
  output logic                            out_valid,
  output logic [CW-1:0]                   out_den,
  output logic [CW-1:0]                   out_rem_x,
  output logic [CW-1:0]                   out_rem_y,
  output logic [gf2d_pkg::FORCE_BITS-1:0] out_q_x,
  output logic [gf2d_pkg::FORCE_BITS-1:0] out_q_y,
  output gf2d_pkg::flags_t                out_flags
);
  import gf2d_pkg::*;

  logic [CW:0] rx2;
  logic [CW:0] ry2;
  logic [CW:0] den_w;
  logic        bit_x;
  logic        bit_y;

  always_comb begin
    rx2   = {in_rem_x, 1'b0};
    ry2   = {in_rem_y, 1'b0};
    den_w = {1'b0, in_den};
    bit_x = rx2 >= den_w;
    bit_y = ry2 >= den_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den   <= in_den;
      out_rem_x <= bit_x ? CW'(rx2 - den_w) : CW'(rx2);
      out_rem_y <= bit_y ? CW'(ry2 - den_w) : CW'(ry2);
      out_q_x   <= {in_q_x[FORCE_BITS-2:0], bit_x};
      out_q_y   <= {in_q_y[FORCE_BITS-2:0], bit_y};
      out_flags <= in_flags;
    end
  end
endmodule

FILE: hw/rtl/gravity_force_2d.sv
// Top level of the 2D gravity force unit: front-end products, root chain, cube, divider chain.
// Depends on gf2d_pkg, gf2d_channels, gf2d_sqrt_cell and gf2d_div_cell.
//
// A body pair enters on pair_in and is taken at a rising edge with valid and ready high.
// One force item leaves on force_out per pair, in the order the pairs were taken.
// Unless force_out stalls, a new pair may enter in every cycle: one item per clock.
// From acceptance to output valid an item passes four front stages, one root cell per
// distance bit (COORD_BITS + 17 bits), four cube and setup stages, 52 divider cells and
// the output register.
// The gain register is written through cfg_wr_en and cfg_wr_data. The user must write it
// only while no item is in flight; the block does not enforce it. Items sample it when taken.
// Reset clears the gain to 6.67 in Q4.8 and drops every item in flight; no item is
// taken while rst is high.
// When the receiver holds ready low with a result waiting, the whole chain holds and
// pair_in.ready falls in the same cycle; nothing is lost or repeated.
// Zero mass and coincident positions give zero force with a status code; an overflowing
// component saturates to all ones with the saturated status.
module gravity_force_2d #(
  parameter int COORD_BITS = gf2d_pkg::COORD_BITS_DEF,
  parameter int MASS_BITS  = gf2d_pkg::MASS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [gf2d_pkg::GAIN_BITS-1:0] cfg_wr_data,
  gf2d_in_if.sink                        pair_in,
  gf2d_out_if.source                     force_out
);
  import gf2d_pkg::*;

  localparam int DW     = COORD_BITS + 1;
  localparam int SSW    = 2 * DW;
  localparam int DBITS  = DW + SQRT_SHIFT / 2;
  localparam int RW     = 2 * DBITS;
  localparam int PW1    = GAIN_BITS + MASS_BITS;
  localparam int PBW    = PW1 + MASS_BITS;
  localparam int NW     = PBW + DW;
  localparam int SQW    = 2 * DBITS;
  localparam int CW     = 3 * DBITS;
  localparam int NCH    = 3;
  localparam int CHW    = (SQW + NCH - 1) / NCH;
  localparam int PPW    = CHW + DBITS;
  localparam int PRESH  = FRAC_SHIFT - FORCE_BITS;
  localparam int MW     = (NW + PRESH > CW) ? NW + PRESH : CW;
  localparam int SIDE_W = 2 * NW;

  logic [GAIN_BITS-1:0] gravity_gain;
  logic                 en;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_gain <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gravity_gain <= cfg_wr_data;
    end
  end

  assign en            = !force_out.valid || force_out.ready;
  assign pair_in.ready = en && !rst;
  assign accept        = pair_in.valid && pair_in.ready;

  logic [DW-1:0] ddx;
  logic [DW-1:0] ddy;

  always_comb begin
    ddx = {pair_in.first_x[COORD_BITS-1], pair_in.first_x}
        - {pair_in.second_x[COORD_BITS-1], pair_in.second_x};
    ddy = {pair_in.first_y[COORD_BITS-1], pair_in.first_y}
        - {pair_in.second_y[COORD_BITS-1], pair_in.second_y};
  end

  // Front stages.
  logic                 v0, v1, v2, v3;
  logic [DW-1:0]        dx0, dy0, dx1, dy1, dx2, dy2;
  logic [MASS_BITS-1:0] m1_0, m2_0, m2_1;
  logic [GAIN_BITS-1:0] gain0;
  flags_t               fl0, fl1, fl2, fl3;
  logic [SSW-1:0]       ssum1, ssum2;
  logic [PW1-1:0]       p1;
  logic [PBW-1:0]       pb2;
  logic [NW-1:0]        px3, py3;
  logic [RW-1:0]        rad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx0   <= ddx[DW-1] ? DW'(~ddx + DW'(1)) : ddx;
      dy0   <= ddy[DW-1] ? DW'(~ddy + DW'(1)) : ddy;
      m1_0  <= pair_in.first_mass;
      m2_0  <= pair_in.second_mass;
      gain0 <= gravity_gain;
      fl0   <= '{zero_mass: (pair_in.first_mass == '0) || (pair_in.second_mass == '0),
                 coincident: (ddx == '0) && (ddy == '0), sat_x: 1'b0, sat_y: 1'b0};

      ssum1 <= (SSW'(dx0) * SSW'(dx0)) + (SSW'(dy0) * SSW'(dy0));
      p1    <= PW1'(gain0) * PW1'(m1_0);
      dx1   <= dx0;
      dy1   <= dy0;
      m2_1  <= m2_0;
      fl1   <= fl0;

      pb2   <= PBW'(p1) * PBW'(m2_1);
      ssum2 <= ssum1;
      dx2   <= dx1;
      dy2   <= dy1;
      fl2   <= fl1;

      px3   <= NW'(pb2) * NW'(dx2);
      py3   <= NW'(pb2) * NW'(dy2);
      rad3  <= {ssum2, {SQRT_SHIFT{1'b0}}};
      fl3   <= fl2;
    end
  end

  // Square root chain.
  logic               sv    [DBITS+1];
  logic [DBITS+1:0]   srem  [DBITS+1];
  logic [DBITS-1:0]   sroot [DBITS+1];
  logic [RW-1:0]      srad  [DBITS+1];
  logic [SIDE_W-1:0]  sside [DBITS+1];
  flags_t             sfl   [DBITS+1];

  assign sv[0]    = v3;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = rad3;
  assign sside[0] = {px3, py3};
  assign sfl[0]   = fl3;

  for (genvar k = 0; k < DBITS; k++) begin : g_sqrt
    gf2d_sqrt_cell #(.DBITS(DBITS), .SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv[k]), .in_rem(srem[k]), .in_root(sroot[k]), .in_rad(srad[k]),
      .in_side(sside[k]), .in_flags(sfl[k]),
      .out_valid(sv[k+1]), .out_rem(srem[k+1]), .out_root(sroot[k+1]),
      .out_rad(srad[k+1]), .out_side(sside[k+1]), .out_flags(sfl[k+1])
    );
  end

  // Cube of the distance and divider setup.
  logic                      c1v, c2v, c3v, c4v;
  logic [SQW-1:0]            sq1;
  logic [DBITS-1:0]          d1;
  logic [NCH-1:0][PPW-1:0]   pp2;
  logic [NCH*CHW-1:0]        sqpad;
  logic [CW-1:0]             cube3, cube4, cube_sum;
  logic [SIDE_W-1:0]         side1, side2, side3;
  flags_t                    cf1, cf2, cf3, cf4;
  logic [MW-1:0]             nx_sh, ny_sh;
  logic [CW-1:0]             remx4, remy4;

  always_comb begin
    sqpad    = (NCH*CHW)'(sq1);
    cube_sum = '0;
    for (int i = 0; i < NCH; i++) begin
      cube_sum = cube_sum + (CW'(pp2[i]) << (i * CHW));
    end
    nx_sh = MW'({side3[SIDE_W-1:NW], {PRESH{1'b0}}});
    ny_sh = MW'({side3[NW-1:0], {PRESH{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1v <= 1'b0;
      c2v <= 1'b0;
      c3v <= 1'b0;
      c4v <= 1'b0;
    end else if (en) begin
      c1v <= sv[DBITS];
      c2v <= c1v;
      c3v <= c2v;
      c4v <= c3v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1   <= SQW'(sroot[DBITS]) * SQW'(sroot[DBITS]);
      d1    <= sroot[DBITS];
      side1 <= sside[DBITS];
      cf1   <= sfl[DBITS];

      for (int i = 0; i < NCH; i++) begin
        pp2[i] <= PPW'(sqpad[i*CHW +: CHW]) * PPW'(d1);
      end
      side2 <= side1;
      cf2   <= cf1;

      cube3 <= cube_sum;
      side3 <= side2;
      cf3   <= cf2;

      cube4 <= cube3;
      remx4 <= CW'(nx_sh);
      remy4 <= CW'(ny_sh);
      cf4   <= '{zero_mass: cf3.zero_mass, coincident: cf3.coincident,
                 sat_x: nx_sh >= MW'(cube3), sat_y: ny_sh >= MW'(cube3)};
    end
  end

  // Divider chain.
  logic                  dv   [FORCE_BITS+1];
  logic [CW-1:0]         dden [FORCE_BITS+1];
  logic [CW-1:0]         drx  [FORCE_BITS+1];
  logic [CW-1:0]         dry  [FORCE_BITS+1];
  logic [FORCE_BITS-1:0] dqx  [FORCE_BITS+1];
  logic [FORCE_BITS-1:0] dqy  [FORCE_BITS+1];
  flags_t                dfl  [FORCE_BITS+1];

  assign dv[0]   = c4v;
  assign dden[0] = cube4;
  assign drx[0]  = remx4;
  assign dry[0]  = remy4;
  assign dqx[0]  = '0;
  assign dqy[0]  = '0;
  assign dfl[0]  = cf4;

  for (genvar k = 0; k < FORCE_BITS; k++) begin : g_div
    gf2d_div_cell #(.CW(CW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(dv[k]), .in_den(dden[k]), .in_rem_x(drx[k]), .in_rem_y(dry[k]),
      .in_q_x(dqx[k]), .in_q_y(dqy[k]), .in_flags(dfl[k]),
      .out_valid(dv[k+1]), .out_den(dden[k+1]), .out_rem_x(drx[k+1]),
      .out_rem_y(dry[k+1]), .out_q_x(dqx[k+1]), .out_q_y(dqy[k+1]),
      .out_flags(dfl[k+1])
    );
  end

  // Output register.
  flags_t                fo;
  logic [FORCE_BITS-1:0] fx_next, fy_next;
  status_t               st_next;

  always_comb begin
    fo = dfl[FORCE_BITS];
    priority if (fo.zero_mass) begin
      fx_next = '0;
      fy_next = '0;
      st_next = STATUS_ZERO_MASS;
    end else if (fo.coincident) begin
      fx_next = '0;
      fy_next = '0;
      st_next = STATUS_COINCIDENT;
    end else begin
      fx_next = fo.sat_x ? FORCE_MAX : dqx[FORCE_BITS];
      fy_next = fo.sat_y ? FORCE_MAX : dqy[FORCE_BITS];
      st_next = (fo.sat_x || fo.sat_y) ? STATUS_SATURATED : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      force_out.valid <= 1'b0;
    end else if (en) begin
      force_out.valid <= dv[FORCE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_out.force_x <= fx_next;
      force_out.force_y <= fy_next;
      force_out.status  <= st_next;
    end
  end

  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    force_out.valid && (force_out.status == STATUS_ZERO_MASS
                        || force_out.status == STATUS_COINCIDENT)
    |-> force_out.force_x == '0 && force_out.force_y == '0)
    else $error("special-case item carries nonzero force");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    force_out.valid && force_out.status == STATUS_SATURATED
    |-> force_out.force_x == FORCE_MAX || force_out.force_y == FORCE_MAX)
    else $error("saturated item has no saturated component");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !force_out.valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    force_out.valid && !force_out.ready |-> !pair_in.ready)
    else $error("pair taken while output stalled");
endmodule
